// ----- design/dts_pkg.sv -----
// Shared types and codes for the deadline timer scheduler.
package dts_pkg;

	localparam logic [2:0] OP_SCHED_PER = 3'd0;
	localparam logic [2:0] OP_SCHED_ONE = 3'd1;
	localparam logic [2:0] OP_CANCEL    = 3'd2;
	localparam logic [2:0] OP_CLEAR     = 3'd3;
	localparam logic [2:0] OP_TICK      = 3'd4;

	localparam logic [2:0] KIND_SCHED     = 3'd0;
	localparam logic [2:0] KIND_FULL      = 3'd1;
	localparam logic [2:0] KIND_CANCELLED = 3'd2;
	localparam logic [2:0] KIND_NOTFOUND  = 3'd3;
	localparam logic [2:0] KIND_CLEARED   = 3'd4;
	localparam logic [2:0] KIND_FIRED     = 3'd5;

	localparam logic [31:0] HALF = 32'h8000_0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic        valid;
		logic        taken;
		logic [31:0] deadline;
		logic [30:0] period;
		logic        periodic;
		logic [31:0] ident;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic write;
		logic clear_all;
		logic clear_taken;
	} cell_ctl_t;

endpackage

// ----- design/dts_cell.sv -----
// One timer slot of the rotating slot chain.
module dts_cell import dts_pkg::*; #(
	parameter int HW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  entry_t        wr_entry,
	input  logic [HW-1:0] wr_handle,
	input  entry_t        nb_entry,
	input  logic [HW-1:0] nb_handle,
	output entry_t        entry,
	output logic [HW-1:0] handle
);

	logic          valid_q;
	logic          taken_q;
	entry_t        pl_q;
	logic [HW-1:0] handle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			taken_q <= 1'b0;
		end else begin
			if (ctl.clear_all)
				valid_q <= 1'b0;
			else if (ctl.write)
				valid_q <= wr_entry.valid;
			else if (ctl.shift)
				valid_q <= nb_entry.valid;
			if (ctl.clear_taken)
				taken_q <= 1'b0;
			else if (ctl.write)
				taken_q <= wr_entry.taken;
			else if (ctl.shift)
				taken_q <= nb_entry.taken;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			pl_q     <= wr_entry;
			handle_q <= wr_handle;
		end else if (ctl.shift) begin
			pl_q     <= nb_entry;
			handle_q <= nb_handle;
		end
	end

	always_comb begin
		entry       = pl_q;
		entry.valid = valid_q;
		entry.taken = taken_q;
	end
	assign handle = handle_q;

endmodule

// ----- design/deadline_timer_scheduler_top.sv -----
// Top level: command decode, slot chain and the earliest-deadline scan.
//
//  channel | dir | beat fields (tdata low bit up)
//  s_*     | in  | opcode[2:0] delay[33:3] immediate[34] task_id[66:35] task_tag[82:67]
//  m_*     | out | kind[2:0] result_id[34:3] result_tag[50:35]; tlast = last
//
// Schedule and clear go from accept through the exec state to the result. Cancel
// makes one full rotation of the slot chain past the head comparator.
// A tick makes one rotation per firing, plus a last rotation that finds none.
// Reset empties the table at once, no clearing pass. An input beat is taken only
// in the idle state; a stalled output stalls the sequencer only.
module deadline_timer_scheduler_top import dts_pkg::*; #(
	parameter int SLOTS    = 16,
	parameter int TAG_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // opcode, delay, immediate, task_id, task_tag
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // kind, result_id, result_tag
	output logic        m_tlast
);

	localparam int IW = $clog2(SLOTS);
	localparam int HW = (TAG_BITS < 16) ? TAG_BITS : 16;

	state_t st_q, st_d;

	logic [2:0]    op_q;
	logic [30:0]   delay_q;
	logic          imm_q;
	logic [31:0]   tid_q;
	logic [HW-1:0] tag_q;

	logic [31:0] time_q, id_q, stamp_q;
	logic [IW-1:0] cnt_q;

	logic          best_found_q;
	logic [31:0]   best_key_q;
	logic [IW-1:0] best_idx_q;
	entry_t        best_e_q;
	logic [HW-1:0] best_h_q;

	logic          pend_q;
	logic [31:0]   pend_id_q;
	logic [HW-1:0] pend_h_q;

	logic        out_v_q;
	logic [2:0]  out_kind_q;
	logic [31:0] out_id_q;
	logic [15:0] out_tag_q;
	logic        out_last_q;

	entry_t        cells[SLOTS];
	logic [HW-1:0] handles[SLOTS];
	cell_ctl_t     ctls[SLOTS];

	logic          shift, clr_all, clr_taken, wr_en;
	logic [IW-1:0] wr_idx;
	entry_t        wr_e;
	logic [HW-1:0] wr_h;

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			localparam int NX = (g == SLOTS - 1) ? 0 : g + 1;
			always_comb begin
				ctls[g].shift       = shift;
				ctls[g].write       = wr_en && (wr_idx == IW'(g));
				ctls[g].clear_all   = clr_all;
				ctls[g].clear_taken = clr_taken;
			end
			dts_cell #(.HW(HW)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctls[g]),
				.wr_entry  (wr_e),
				.wr_handle (wr_h),
				.nb_entry  (cells[NX]),
				.nb_handle (handles[NX]),
				.entry     (cells[g]),
				.handle    (handles[g])
			);
		end
	endgenerate

	// lowest free slot, chain at rest
	logic          free_found;
	logic [IW-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!cells[i].valid) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// head comparator
	logic [31:0] head_key, st_diff;
	logic        cand, earlier;
	always_comb begin
		head_key = cells[0].deadline - time_q + HALF;
		st_diff  = cells[0].stamp - best_e_q.stamp;
		earlier  = !best_found_q || (head_key < best_key_q) ||
		           ((head_key == best_key_q) && st_diff[31]);
		if (op_q == OP_CANCEL)
			cand = cells[0].valid && (cells[0].ident == tid_q);
		else
			cand = cells[0].valid && !cells[0].taken && (head_key <= HALF);
	end

	logic out_free;
	assign out_free = !out_v_q || m_tready;
	assign s_tready = (st_q == ST_IDLE);

	logic          emit, emit_last, best_load, best_clear, cnt_clear;
	logic          time_inc, id_inc, stamp_inc, pend_load, pend_clear;
	logic [2:0]    emit_kind;
	logic [31:0]   emit_id;
	logic [HW-1:0] emit_tag;
	logic [31:0]   new_id;
	assign new_id = id_q + 32'd1;

	always_comb begin
		st_d       = st_q;
		emit       = 1'b0;
		emit_kind  = KIND_SCHED;
		emit_id    = '0;
		emit_tag   = '0;
		emit_last  = 1'b1;
		shift      = 1'b0;
		clr_all    = 1'b0;
		clr_taken  = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = best_idx_q;
		wr_e       = best_e_q;
		wr_h       = best_h_q;
		best_load  = 1'b0;
		best_clear = 1'b0;
		cnt_clear  = 1'b0;
		time_inc   = 1'b0;
		id_inc     = 1'b0;
		stamp_inc  = 1'b0;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (s_tvalid)
					st_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (op_q) inside
					OP_SCHED_PER, OP_SCHED_ONE: begin
						if (out_free) begin
							emit = 1'b1;
							st_d = ST_IDLE;
							if (!free_found) begin
								emit_kind = KIND_FULL;
							end else begin
								emit_id          = new_id;
								id_inc           = 1'b1;
								stamp_inc        = 1'b1;
								wr_en            = 1'b1;
								wr_idx           = free_idx;
								wr_h             = tag_q;
								wr_e.valid       = 1'b1;
								wr_e.taken       = 1'b0;
								wr_e.periodic    = (op_q == OP_SCHED_PER);
								wr_e.ident       = new_id;
								wr_e.stamp       = stamp_q;
								if (op_q == OP_SCHED_PER) begin
									wr_e.period   = (delay_q == '0) ? 31'd1 : delay_q;
									wr_e.deadline = imm_q ? time_q : time_q + {1'b0, delay_q};
								end else begin
									wr_e.period   = '0;
									wr_e.deadline = time_q + {1'b0, delay_q};
								end
							end
						end
					end
					OP_CANCEL: begin
						best_clear = 1'b1;
						cnt_clear  = 1'b1;
						st_d       = ST_SCAN;
					end
					OP_CLEAR: begin
						if (out_free) begin
							emit      = 1'b1;
							emit_kind = KIND_CLEARED;
							clr_all   = 1'b1;
							st_d      = ST_IDLE;
						end
					end
					OP_TICK: begin
						time_inc   = 1'b1;
						clr_taken  = 1'b1;
						pend_clear = 1'b1;
						best_clear = 1'b1;
						cnt_clear  = 1'b1;
						st_d       = ST_SCAN;
					end
					default: st_d = ST_IDLE;
				endcase
			end
			ST_SCAN: begin
				shift     = 1'b1;
				best_load = cand && earlier;
				if (cnt_q == IW'(SLOTS - 1))
					st_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					if (op_q == OP_CANCEL) begin
						emit       = 1'b1;
						emit_kind  = best_found_q ? KIND_CANCELLED : KIND_NOTFOUND;
						emit_id    = tid_q;
						wr_en      = best_found_q;
						wr_e.valid = 1'b0;
						st_d       = ST_IDLE;
					end else if (best_found_q) begin
						wr_en         = 1'b1;
						wr_e.valid    = best_e_q.periodic;
						wr_e.taken    = 1'b1;
						wr_e.deadline = best_e_q.deadline + {1'b0, best_e_q.period};
						wr_e.stamp    = stamp_q;
						stamp_inc     = best_e_q.periodic;
						emit          = pend_q;
						emit_kind     = KIND_FIRED;
						emit_id       = pend_id_q;
						emit_tag      = pend_h_q;
						emit_last     = 1'b0;
						pend_load     = 1'b1;
						best_clear    = 1'b1;
						cnt_clear     = 1'b1;
						st_d          = ST_SCAN;
					end else begin
						emit      = pend_q;
						emit_kind = KIND_FIRED;
						emit_id   = pend_id_q;
						emit_tag  = pend_h_q;
						st_d      = ST_IDLE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			time_q       <= '0;
			id_q         <= '0;
			stamp_q      <= '0;
			cnt_q        <= '0;
			best_found_q <= 1'b0;
			pend_q       <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			st_q <= st_d;
			if (time_inc)
				time_q <= time_q + 32'd1;
			if (id_inc)
				id_q <= new_id;
			if (stamp_inc)
				stamp_q <= stamp_q + 32'd1;
			if (cnt_clear)
				cnt_q <= '0;
			else if (st_q == ST_SCAN)
				cnt_q <= cnt_q + IW'(1);
			if (best_clear)
				best_found_q <= 1'b0;
			else if (best_load)
				best_found_q <= 1'b1;
			if (pend_clear)
				pend_q <= 1'b0;
			else if (pend_load)
				pend_q <= 1'b1;
			if (emit)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= s_tdata[2:0];
			delay_q <= s_tdata[33:3];
			imm_q   <= s_tdata[34];
			tid_q   <= s_tdata[66:35];
			tag_q   <= s_tdata[67 +: HW];
		end
		if (best_load) begin
			best_key_q <= head_key;
			best_idx_q <= cnt_q;
			best_e_q   <= cells[0];
			best_h_q   <= handles[0];
		end
		if (pend_load) begin
			pend_id_q <= best_e_q.ident;
			pend_h_q  <= best_h_q;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_id_q   <= emit_id;
			out_tag_q  <= 16'(emit_tag);
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_tag_q, out_id_q, out_kind_q};
	assign m_tlast  = out_last_q;

	a_cancel_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FINISH && op_q == OP_CANCEL && best_found_q && out_free)
		|=> !cells[$past(best_idx_q)].valid)
		else $error("cancelled slot still valid");

	a_nonlast_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[2:0] == KIND_FIRED))
		else $error("non-final beat that is not a firing");

	a_stamp_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(stamp_q) |-> ($past(st_q) == ST_EXEC || $past(st_q) == ST_FINISH))
		else $error("stamp counter moved outside exec or finish");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> (!wr_en && !clr_all && !emit))
		else $error("slot write or beat during rotation");

endmodule
